[design/bth_pkg.sv]
// Shared constants, datapath command and status types for the boundary tag allocator.
`timescale 1ns / 1ps
package bth_pkg;

	localparam int HEAP_BYTES_DEF = 8192;
	localparam int TAG_BITS       = 13;
	localparam int SIZE_W         = 14;
	localparam int OFF_W          = 13;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_CLR,
		OP_LOAD,
		OP_A_RD,
		OP_A_EVAL,
		OP_SP1,
		OP_SP2,
		OP_SP3,
		OP_SP4,
		OP_WH1,
		OP_WH2,
		OP_F_RD0,
		OP_F_N,
		OP_W_TW,
		OP_W_BW,
		OP_F_RDA,
		OP_F_EA,
		OP_F_RDB,
		OP_F_EB,
		OP_FAIL
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
	} dp_cmd_t;

	typedef struct packed {
		logic clr_last;
		logic a_chk_ok;
		logic fit_split;
		logic fit_whole;
		logic tw_pos;
		logic bw_low;
		logic rd_pos;
	} dp_stat_t;

endpackage

[design/bth_ram.sv]
// Generic single-port RAM with registered read data.
`timescale 1ns / 1ps
module bth_ram #(
	parameter int WIDTH = 13,
	parameter int DEPTH = 2048,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    addr,
	input  logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

[design/bth_datapath.sv]
// Datapath: tag store, walk and merge registers, address and tag arithmetic, result register.
`timescale 1ns / 1ps
module bth_datapath import bth_pkg::*; #(
	parameter int HEAP_BYTES = HEAP_BYTES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  dp_cmd_t           cmd,
	input  logic [SIZE_W-1:0] size_bytes,
	input  logic [OFF_W-1:0]  data_offset,
	output dp_stat_t          stat,
	output logic [OFF_W-1:0]  result_offset,
	output logic              success
);

	localparam int DEPTH = HEAP_BYTES / 4;
	localparam int AW    = $clog2(DEPTH);
	localparam int SW    = ((AW > TAG_BITS) ? AW : TAG_BITS) + 5;

	typedef logic signed [SW-1:0] sw_t;

	localparam sw_t DEPTH_S = sw_t'(DEPTH);
	localparam sw_t C2      = sw_t'(2);
	localparam sw_t C4      = sw_t'(4);
	localparam logic [TAG_BITS-1:0] INIT_TAG = TAG_BITS'(DEPTH - 4);
	localparam logic [AW-1:0] TOP_TAG_W = AW'(DEPTH - 2);
	localparam logic [AW-1:0] LAST_W    = AW'(DEPTH - 1);

	sw_t iw_q, n_q, tw_q, bw_q, pw_q, val_q;
	logic [AW-1:0] clr_q;
	logic rd_ok_q;
	logic [OFF_W-1:0] off_q;
	logic ok_q;

	logic [TAG_BITS-1:0] rdata;
	sw_t rdv, a, wdat, d_sp, d_wh, rest, abs_rdv;
	logic we, rd, in_rng;
	logic ram_we;
	logic [AW-1:0] ram_addr;
	logic [TAG_BITS-1:0] ram_wdata;

	assign rdv     = rd_ok_q ? sw_t'(signed'(rdata)) : '0;
	assign abs_rdv = (rdv < 0) ? -rdv : rdv;
	assign d_sp    = iw_q - n_q;
	assign d_wh    = iw_q - val_q;
	assign rest    = val_q - C4 - n_q;

	always_comb begin
		a    = '0;
		wdat = '0;
		we   = 1'b0;
		rd   = 1'b0;
		case (cmd.op)
			OP_A_RD: begin
				a  = iw_q;
				rd = 1'b1;
			end
			OP_SP1: begin
				a    = iw_q;
				wdat = -n_q;
				we   = 1'b1;
			end
			OP_SP2: begin
				a    = iw_q - n_q - C2;
				wdat = -n_q;
				we   = 1'b1;
			end
			OP_SP3: begin
				a    = iw_q - n_q - C4;
				wdat = rest;
				we   = 1'b1;
			end
			OP_SP4: begin
				a    = iw_q - val_q - C2;
				wdat = rest;
				we   = 1'b1;
			end
			OP_WH1: begin
				a    = iw_q;
				wdat = -val_q;
				we   = 1'b1;
			end
			OP_WH2: begin
				a    = iw_q - val_q - C2;
				wdat = -val_q;
				we   = 1'b1;
			end
			OP_F_RD0: begin
				a  = tw_q;
				rd = 1'b1;
			end
			OP_W_TW: begin
				a    = tw_q;
				wdat = val_q;
				we   = 1'b1;
			end
			OP_W_BW: begin
				a    = bw_q;
				wdat = val_q;
				we   = 1'b1;
			end
			OP_F_RDA: begin
				a  = pw_q - C4;
				rd = 1'b1;
			end
			OP_F_RDB: begin
				a  = bw_q + C2;
				rd = 1'b1;
			end
			default: begin
				a = '0;
			end
		endcase
	end

	assign in_rng = (a >= 0) && (a < DEPTH_S);

	always_comb begin
		if (cmd.op == OP_CLR) begin
			ram_we    = 1'b1;
			ram_addr  = clr_q;
			ram_wdata = ((clr_q == '0) || (clr_q == TOP_TAG_W)) ? INIT_TAG : '0;
		end else begin
			ram_we    = we & in_rng;
			ram_addr  = a[AW-1:0];
			ram_wdata = wdat[TAG_BITS-1:0];
		end
	end

	bth_ram #(
		.WIDTH(TAG_BITS),
		.DEPTH(DEPTH)
	) u_tag_ram (
		.clk  (clk),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(ram_wdata),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q   <= '0;
			rd_ok_q <= 1'b0;
		end else begin
			rd_ok_q <= rd & in_rng;
			if (cmd.op == OP_CLR) begin
				clr_q <= clr_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				n_q   <= sw_t'(({1'b0, size_bytes} + 15'd3) >> 2);
				iw_q  <= DEPTH_S - C2;
				pw_q  <= sw_t'(data_offset >> 2);
				tw_q  <= sw_t'(data_offset >> 2) - C2;
				off_q <= '0;
				ok_q  <= 1'b1;
			end
			OP_A_EVAL: begin
				val_q <= rdv;
				if (!stat.fit_split && !stat.fit_whole) begin
					iw_q <= iw_q - abs_rdv - C4;
				end
			end
			OP_SP1: off_q <= {d_sp[OFF_W-3:0], 2'b00};
			OP_WH1: off_q <= {d_wh[OFF_W-3:0], 2'b00};
			OP_F_N: begin
				val_q <= -rdv;
				bw_q  <= pw_q - rdv;
			end
			OP_F_EA: begin
				if (stat.rd_pos) begin
					val_q <= rdv + val_q + C4;
					tw_q  <= tw_q - C4 - rdv;
				end
			end
			OP_F_EB: begin
				if (stat.rd_pos) begin
					val_q <= rdv + val_q + C4;
					bw_q  <= bw_q + C4 + rdv;
				end
			end
			OP_FAIL: begin
				off_q <= '0;
				ok_q  <= 1'b0;
			end
			default: begin
				ok_q <= ok_q;
			end
		endcase
	end

	assign stat.clr_last  = (clr_q == LAST_W);
	assign stat.a_chk_ok  = (iw_q - n_q - C2) >= 0;
	assign stat.fit_split = rdv > (n_q + C4);
	assign stat.fit_whole = rdv >= n_q;
	assign stat.tw_pos    = tw_q > 0;
	assign stat.bw_low    = bw_q < (DEPTH_S - C2);
	assign stat.rd_pos    = rdv > 0;

	assign result_offset = off_q;
	assign success       = ok_q;

endmodule

[design/bth_ctrl.sv]
// Controller: clear pass, first-fit walk, split, free and merge sequencing, handshakes.
`timescale 1ns / 1ps
module bth_ctrl import bth_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_stall,
	input  logic     mode,
	output logic     rsp_valid,
	input  logic     rsp_stall,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	typedef enum logic [22:0] {
		S_CLR   = 23'd1 << 0,
		S_IDLE  = 23'd1 << 1,
		S_A_CHK = 23'd1 << 2,
		S_A_EV  = 23'd1 << 3,
		S_SP1   = 23'd1 << 4,
		S_SP2   = 23'd1 << 5,
		S_SP3   = 23'd1 << 6,
		S_SP4   = 23'd1 << 7,
		S_WH1   = 23'd1 << 8,
		S_WH2   = 23'd1 << 9,
		S_F_RD0 = 23'd1 << 10,
		S_F_N   = 23'd1 << 11,
		S_F_W1  = 23'd1 << 12,
		S_F_W2  = 23'd1 << 13,
		S_F_RDA = 23'd1 << 14,
		S_F_EA  = 23'd1 << 15,
		S_F_W3  = 23'd1 << 16,
		S_F_W4  = 23'd1 << 17,
		S_F_CB  = 23'd1 << 18,
		S_F_EB  = 23'd1 << 19,
		S_F_W5  = 23'd1 << 20,
		S_F_W6  = 23'd1 << 21,
		S_DONE  = 23'd1 << 22
	} state_t;

	state_t state_q, state_d;
	logic rsp_valid_q;
	logic take;

	assign take      = rsp_valid_q && !rsp_stall;
	assign req_stall = !((state_q == S_IDLE) && (!rsp_valid_q || !rsp_stall));
	assign rsp_valid = rsp_valid_q;

	always_comb begin
		state_d = state_q;
		cmd.op  = OP_NONE;
		case (state_q)
			S_CLR: begin
				cmd.op = OP_CLR;
				if (stat.clr_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (req_valid && !req_stall) begin
					cmd.op  = OP_LOAD;
					state_d = mode ? S_F_RD0 : S_A_CHK;
				end
			end
			S_A_CHK: begin
				if (stat.a_chk_ok) begin
					cmd.op  = OP_A_RD;
					state_d = S_A_EV;
				end else begin
					cmd.op  = OP_FAIL;
					state_d = S_DONE;
				end
			end
			S_A_EV: begin
				cmd.op = OP_A_EVAL;
				if (stat.fit_split)      state_d = S_SP1;
				else if (stat.fit_whole) state_d = S_WH1;
				else                     state_d = S_A_CHK;
			end
			S_SP1: begin
				cmd.op  = OP_SP1;
				state_d = S_SP2;
			end
			S_SP2: begin
				cmd.op  = OP_SP2;
				state_d = S_SP3;
			end
			S_SP3: begin
				cmd.op  = OP_SP3;
				state_d = S_SP4;
			end
			S_SP4: begin
				cmd.op  = OP_SP4;
				state_d = S_DONE;
			end
			S_WH1: begin
				cmd.op  = OP_WH1;
				state_d = S_WH2;
			end
			S_WH2: begin
				cmd.op  = OP_WH2;
				state_d = S_DONE;
			end
			S_F_RD0: begin
				cmd.op  = OP_F_RD0;
				state_d = S_F_N;
			end
			S_F_N: begin
				cmd.op  = OP_F_N;
				state_d = S_F_W1;
			end
			S_F_W1: begin
				cmd.op  = OP_W_TW;
				state_d = S_F_W2;
			end
			S_F_W2: begin
				cmd.op  = OP_W_BW;
				state_d = stat.tw_pos ? S_F_RDA : S_F_CB;
			end
			S_F_RDA: begin
				cmd.op  = OP_F_RDA;
				state_d = S_F_EA;
			end
			S_F_EA: begin
				cmd.op  = OP_F_EA;
				state_d = stat.rd_pos ? S_F_W3 : S_F_CB;
			end
			S_F_W3: begin
				cmd.op  = OP_W_TW;
				state_d = S_F_W4;
			end
			S_F_W4: begin
				cmd.op  = OP_W_BW;
				state_d = S_F_CB;
			end
			S_F_CB: begin
				if (stat.bw_low) begin
					cmd.op  = OP_F_RDB;
					state_d = S_F_EB;
				end else begin
					state_d = S_DONE;
				end
			end
			S_F_EB: begin
				cmd.op  = OP_F_EB;
				state_d = stat.rd_pos ? S_F_W5 : S_DONE;
			end
			S_F_W5: begin
				cmd.op  = OP_W_TW;
				state_d = S_F_W6;
			end
			S_F_W6: begin
				cmd.op  = OP_W_BW;
				state_d = S_DONE;
			end
			S_DONE: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_CLR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_DONE) begin
				rsp_valid_q <= 1'b1;
			end else if (take) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

endmodule

[design/boundary_tag_heap_allocator.sv]
// Top level: boundary tag first-fit heap allocator with coalescing free.
//
//   channel  valid      stall      payload
//   request  req_valid  req_stall  mode, size_bytes, data_offset
//   response rsp_valid  rsp_stall  result_offset, success
//
// After reset a clearing pass writes all HEAP_BYTES/4 words of the tag store, with req_stall high.
// Allocate: walks the blocks from the top tag down, reading and checking each, then makes 2 or 4
// tag writes and posts the result; a miss ends with a failed check and the post.
// The number of blocks walked over the single-port tag RAM sets how long it takes.
// Free: reads the block's tag and writes both its tags, then the tag reads and writes of the two merges.
// One request is in work at a time; a new request is taken at the earliest in the cycle
// the previous result is taken.
`timescale 1ns / 1ps
module boundary_tag_heap_allocator import bth_pkg::*; #(
	parameter int HEAP_BYTES = HEAP_BYTES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  logic              mode,
	input  logic [SIZE_W-1:0] size_bytes,
	input  logic [OFF_W-1:0]  data_offset,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output logic [OFF_W-1:0]  result_offset,
	output logic              success
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	bth_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.mode     (mode),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	bth_datapath #(
		.HEAP_BYTES(HEAP_BYTES)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.size_bytes   (size_bytes),
		.data_offset  (data_offset),
		.stat         (stat),
		.result_offset(result_offset),
		.success      (success)
	);

endmodule
